### src/tcw_pkg.sv
package tcw_pkg;

    // Field widths of the item ports
    localparam int REQ_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int CURSOR_W     = 11;
    localparam int VALUE_W      = 16;
    localparam int ATTR_W       = 8;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Character and attribute constants
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

    // Request codes on req_type
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Classified command kinds
    typedef enum logic [2:0] {
        CMD_CHAR,
        CMD_NEWLINE,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [CHAR_W-1:0]        ch;
        logic [CELL_INDEX_W-1:0]  idx;
    } cmd_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_BLANK,
        ST_FILL
    } back_state_t;

    // Status from back end to front end
    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

### src/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/tcw_queue.sv
module tcw_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tcw_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_take,
    output tcw_pkg::cmd_t pop_cmd
);

    localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcw_pkg::cmd_t    slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_take && pop_valid;

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/tcw_front.sv
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tcw_pkg::REQ_W-1:0]         req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::CELL_INDEX_W-1:0]  cell_index,
    input  tcw_pkg::back_status_t             status,
    output logic                              push_valid,
    input  logic                              push_ready,
    output tcw_pkg::cmd_t                     push_cmd
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CMP_W = AW + tcw_pkg::CELL_INDEX_W;

    logic in_range;

    // Hold off items while the queue is full or the screen is being set up
    assign in_stall   = !push_ready || status.init_busy;
    assign push_valid = in_valid && !in_stall;

    assign in_range = ({{AW{1'b0}}, cell_index} < CMP_W'(CELLS));

    // Classify the request
    always_comb
    begin
        push_cmd.ch  = char_code;
        push_cmd.idx = cell_index;
        case (req_type)
            tcw_pkg::REQ_PUT:
            begin
                push_cmd.kind = (char_code == tcw_pkg::NEWLINE_CODE) ?
                                tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_CHAR;
            end
            tcw_pkg::REQ_CLEAR:
            begin
                push_cmd.kind = tcw_pkg::CMD_CLEAR;
            end
            tcw_pkg::REQ_READ:
            begin
                push_cmd.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_NOP;
            end
            default:
            begin
                push_cmd.kind = tcw_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

### src/tcw_back.sv
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]      cfg_data,
    input  logic                            cmd_valid,
    output logic                            cmd_take,
    input  tcw_pkg::cmd_t                   cmd,
    output tcw_pkg::back_status_t           status,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tcw_pkg::CURSOR_W-1:0]    cursor_position,
    output logic [tcw_pkg::VALUE_W-1:0]     cell_value,
    output logic                            scrolled
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int VW     = tcw_pkg::VALUE_W;
    localparam int CW     = tcw_pkg::CURSOR_W;
    localparam logic [AW-1:0]    COPY_LEN    = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0]    LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0]    BOTTOM_POS  = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0]    COLS_AW     = AW'(COLUMNS);
    localparam logic [COL_W-1:0] LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [VW-1:0]    RESET_BLANK = {tcw_pkg::ATTR_RESET, tcw_pkg::SPACE_CODE};

    tcw_pkg::back_state_t state_reg, state_next;

    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic [VW-1:0]              blank_reg, blank_next;
    logic [AW-1:0]              cnt_reg, cnt_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [AW-1:0]              pos_reg, pos_next;

    logic                       out_valid_reg, out_valid_next;
    logic [CW-1:0]              cursor_reg, cursor_next;
    logic [VW-1:0]              value_reg, value_next;
    logic                       scrolled_reg, scrolled_next;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [VW-1:0]              ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [VW-1:0]              ram_rdata;

    logic                       out_free;
    logic                       done;
    logic                       scroll_start;

    tcw_ram #(
        .WIDTH (VW),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready        = 1'b1;
    assign status.init_busy = (state_reg == tcw_pkg::ST_INIT);
    assign out_free         = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign cursor_position = cursor_reg;
    assign cell_value      = value_reg;
    assign scrolled        = scrolled_reg;

    // Sequencer: execute one command, sweep the screen for clear and scroll
    always_comb
    begin
        state_next    = state_reg;
        blank_next    = blank_reg;
        cnt_next      = cnt_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pos_next      = pos_reg;
        cmd_take      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = blank_reg;
        ram_raddr     = AW'({{AW{1'b0}}, cmd.idx});
        done          = 1'b0;
        scroll_start  = 1'b0;
        value_next    = '0;
        scrolled_next = 1'b0;

        case (state_reg)
            tcw_pkg::ST_INIT, tcw_pkg::ST_FILL:
            begin
                // Fill one cell with the blank value
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                    done       = (state_reg == tcw_pkg::ST_FILL);
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_take = 1'b1;
                    case (cmd.kind)
                        tcw_pkg::CMD_CHAR:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg;
                            ram_wdata = {attr_reg, cmd.ch};
                            if (col_reg == LAST_COL)
                            begin
                                if (row_reg == LAST_ROW)
                                begin
                                    scroll_start = 1'b1;
                                end
                                else
                                begin
                                    col_next = '0;
                                    row_next = row_reg + 1'b1;
                                    pos_next = pos_reg + 1'b1;
                                    done     = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                pos_next = pos_reg + 1'b1;
                                done     = 1'b1;
                            end
                        end
                        tcw_pkg::CMD_NEWLINE:
                        begin
                            if (row_reg == LAST_ROW)
                            begin
                                scroll_start = 1'b1;
                            end
                            else
                            begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                                pos_next = pos_reg + COLS_AW - AW'({{AW{1'b0}}, col_reg});
                                done     = 1'b1;
                            end
                        end
                        tcw_pkg::CMD_CLEAR:
                        begin
                            blank_next = {attr_reg, tcw_pkg::SPACE_CODE};
                            cnt_next   = '0;
                            col_next   = '0;
                            row_next   = '0;
                            pos_next   = '0;
                            state_next = tcw_pkg::ST_FILL;
                        end
                        tcw_pkg::CMD_READ:
                        begin
                            state_next = tcw_pkg::ST_READ;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                    if (scroll_start)
                    begin
                        blank_next = {attr_reg, tcw_pkg::SPACE_CODE};
                        cnt_next   = '0;
                        col_next   = '0;
                        row_next   = LAST_ROW;
                        pos_next   = BOTTOM_POS;
                        state_next = tcw_pkg::ST_COPY;
                    end
                end
            end
            tcw_pkg::ST_READ:
            begin
                value_next = ram_rdata;
                done       = 1'b1;
                state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_COPY:
            begin
                // Write back the cell read last cycle one row higher
                ram_raddr = cnt_reg + COLS_AW;
                ram_waddr = cnt_reg - 1'b1;
                ram_wdata = ram_rdata;
                ram_we    = (cnt_reg != '0);
                if (cnt_reg == COPY_LEN)
                begin
                    state_next = tcw_pkg::ST_BLANK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tcw_pkg::ST_BLANK:
            begin
                // Blank the bottom row
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                if (cnt_reg == LAST_CELL)
                begin
                    scrolled_next = 1'b1;
                    done          = 1'b1;
                    state_next    = tcw_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase

        // Load the result register or drop a taken result
        cursor_next = CW'({{CW{1'b0}}, pos_next});
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            attr_reg      <= tcw_pkg::ATTR_RESET;
            blank_reg     <= RESET_BLANK;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blank_reg     <= blank_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            cursor_reg   <= cursor_next;
            value_reg    <= value_next;
            scrolled_reg <= scrolled_next;
        end
    end

endmodule

### src/text_console_writer_core.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  req_type, char_code, cell_index
// out       out_valid / out_stall cursor_position, cell_value, scrolled
// cfg       cfg_valid / cfg_ready cell_attribute
//
// A put without scroll, an unused request or an out-of-range read completes in the
// back end when taken; an in-range read also needs the registered screen RAM read.
// A scroll runs through the take, a read lead-in, the row copies and the bottom row blank.
// A clear is taken, then does one RAM write per cell.
// After reset the screen RAM is filled with blanks; in_stall is high meanwhile.
// A two-entry command queue lets input be accepted while the back end sweeps or is stalled.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tcw_pkg::REQ_W-1:0]         req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tcw_pkg::CELL_INDEX_W-1:0]  cell_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tcw_pkg::CURSOR_W-1:0]      cursor_position,
    output logic [tcw_pkg::VALUE_W-1:0]       cell_value,
    output logic                              scrolled,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]        cell_attribute
);

    tcw_pkg::back_status_t status;
    tcw_pkg::cmd_t         push_cmd;
    tcw_pkg::cmd_t         pop_cmd;
    logic                  push_valid;
    logic                  push_ready;
    logic                  pop_valid;
    logic                  pop_take;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .cell_index (cell_index),
        .status     (status),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_take   (pop_take),
        .pop_cmd    (pop_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cell_attribute),
        .cmd_valid       (pop_valid),
        .cmd_take        (pop_take),
        .cmd             (pop_cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_position (cursor_position),
        .cell_value      (cell_value),
        .scrolled        (scrolled)
    );

endmodule
